[rtl/core/bops_pkg.sv]
// Shared types, widths and constants of the barrier option payoff statistics block.
package bops_pkg;

    localparam int PRICE_W   = 32;
    localparam int DISC_W    = 17;
    localparam int KIND_W    = 3;
    localparam int SUM_W     = 56;
    localparam int MAX_PATHS = 16777216;
    localparam int CNT_W     = $clog2(MAX_PATHS + 1);
    localparam int PROD_W    = PRICE_W + DISC_W;
    localparam int FRAC_W    = 16;
    localparam int DIV_CNT_W = $clog2(SUM_W);
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam int M_DATA_W  = 160;

    localparam logic [DISC_W-1:0] ONE_Q16 = DISC_W'(65536);

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_KIND     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIKE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BARRIER  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT = 2'd3;

    // Bit positions inside barrier_kind.
    localparam int KIND_PUT  = 2;
    localparam int KIND_DOWN = 1;
    localparam int KIND_IN   = 0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GATE,
        ST_MUL,
        ST_ACC,
        ST_DSTART,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic take;       // sample transfer this cycle
        logic gate;       // barrier test and vanilla value
        logic mul;        // discounting multiply
        logic acc;        // run statistics update
        logic div_start;  // launch the mean division
        logic load_out;   // move the result into the output register
    } ctrl_cmd_t;

    typedef struct packed {
        logic batch;      // the finished path closes the run
        logic div_done;   // quotient ready
        logic out_free;   // output register can take a result
    } ctrl_stat_t;

endpackage

[rtl/core/barrier_option_payoff_stats.sv]
// Top level of the barrier option payoff statistics block.
// Samples that do not end a path are taken one per cycle and give no result.
// A path end sample holds off input through the barrier test, discount multiply,
// statistics update and output load; more while the output register is still full.
// A run end adds the mean division, which makes one quotient bit per cycle.
// Synchronous active-low reset restores register defaults and clears all run state.
module barrier_option_payoff_stats (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [bops_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [bops_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [bops_pkg::PRICE_W-1:0]       s_tdata,   // price
    input  logic                               s_tlast,   // path_end
    input  logic                               s_tuser,   // batch_end
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // payoff, mean_payoff, best_payoff, worst_payoff, path_total, zero fill
    output logic [bops_pkg::M_DATA_W-1:0]      m_tdata,
    output logic                               m_tuser    // stats_valid
);

    bops_pkg::ctrl_cmd_t  cmd;
    bops_pkg::ctrl_stat_t stat;

    bops_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bops_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .s_price     (s_tdata),
        .s_batch_end (s_tuser),
        .cmd         (cmd),
        .stat        (stat),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

[rtl/core/bops_div.sv]
// Restoring divider, one quotient bit per cycle, for the mean payoff.
module bops_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [bops_pkg::SUM_W-1:0]   dividend,
    input  logic [bops_pkg::CNT_W-1:0]   divisor,
    output logic                         done,
    output logic [bops_pkg::SUM_W-1:0]   quotient
);

    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [bops_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [bops_pkg::SUM_W-1:0]     dq_reg, dq_next;
    logic [bops_pkg::CNT_W-1:0]     dvs_reg, dvs_next;
    logic [bops_pkg::CNT_W-1:0]     rem_reg, rem_next;
    logic [bops_pkg::CNT_W:0]       rem_sh;
    logic [bops_pkg::CNT_W:0]       rem_sub;
    logic                           fits;

    // The dividend shifts out at the top while quotient bits enter at the bottom.
    assign rem_sh  = {rem_reg, dq_reg[bops_pkg::SUM_W-1]};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};
    assign fits    = (rem_sh >= {1'b0, dvs_reg});

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dq_next   = dq_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dq_next   = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
        end else if (busy_reg) begin
            dq_next  = {dq_reg[bops_pkg::SUM_W-2:0], fits};
            rem_next = fits ? rem_sub[bops_pkg::CNT_W-1:0] : rem_sh[bops_pkg::CNT_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == bops_pkg::DIV_CNT_W'(bops_pkg::SUM_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dq_reg  <= dq_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = dq_reg;

endmodule

[rtl/core/bops_dp.sv]
// Datapath: configuration, path extremes, payoff, run statistics and output register.
module bops_dp (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [bops_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [bops_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic [bops_pkg::PRICE_W-1:0]       s_price,
    input  logic                               s_batch_end,
    input  bops_pkg::ctrl_cmd_t                cmd,
    output bops_pkg::ctrl_stat_t               stat,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [bops_pkg::M_DATA_W-1:0]      m_tdata,
    output logic                               m_tuser
);

    localparam int PW = bops_pkg::PRICE_W;

    logic [bops_pkg::KIND_W-1:0] kind_reg;
    logic [PW-1:0]               strike_reg;
    logic [PW-1:0]               barrier_reg;
    logic [bops_pkg::DISC_W-1:0] disc_reg;

    logic [PW-1:0]               high_reg, low_reg, last_reg;
    logic                        batch_reg;
    logic [PW-1:0]               value_reg, pay_reg;
    logic [bops_pkg::SUM_W-1:0]  sum_reg;
    logic [PW-1:0]               best_reg, worst_reg;
    logic [bops_pkg::CNT_W-1:0]  count_reg;

    logic                        out_valid_reg;
    logic [PW-1:0]               out_pay_reg, out_mean_reg, out_best_reg, out_worst_reg;
    logic [bops_pkg::CNT_W-1:0]  out_total_reg;
    logic                        out_stats_reg;

    logic                        hit, pays;
    logic [PW:0]                 up_diff, down_diff;
    logic [PW-1:0]               value_next;
    logic [bops_pkg::DISC_W-1:0] disc_eff;
    logic [bops_pkg::PROD_W-1:0] prod;
    logic                        div_done;
    logic [bops_pkg::SUM_W-1:0]  quotient;
    logic [PW-1:0]               mean;

    // Barrier test on the extremes, which already hold the path's last sample.
    always_comb begin
        if (kind_reg[bops_pkg::KIND_DOWN]) begin
            hit = (low_reg <= barrier_reg);
        end else begin
            hit = (high_reg >= barrier_reg);
        end
        pays      = (hit == kind_reg[bops_pkg::KIND_IN]);
        up_diff   = {1'b0, last_reg} - {1'b0, strike_reg};
        down_diff = {1'b0, strike_reg} - {1'b0, last_reg};
        if (!pays) begin
            value_next = '0;
        end else if (kind_reg[bops_pkg::KIND_PUT]) begin
            value_next = down_diff[PW] ? '0 : down_diff[PW-1:0];
        end else begin
            value_next = up_diff[PW] ? '0 : up_diff[PW-1:0];
        end
    end

    assign disc_eff = (disc_reg > bops_pkg::ONE_Q16) ? bops_pkg::ONE_Q16 : disc_reg;
    assign prod     = value_reg * disc_eff;

    bops_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (sum_reg),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    assign mean = (count_reg == '0) ? '0 : quotient[PW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg      <= '0;
            strike_reg    <= '0;
            barrier_reg   <= '0;
            disc_reg      <= bops_pkg::ONE_Q16;
            high_reg      <= '0;
            low_reg       <= '1;
            sum_reg       <= '0;
            best_reg      <= '0;
            worst_reg     <= '1;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    bops_pkg::CFG_KIND:     kind_reg    <= cfg_wdata[bops_pkg::KIND_W-1:0];
                    bops_pkg::CFG_STRIKE:   strike_reg  <= cfg_wdata[PW-1:0];
                    bops_pkg::CFG_BARRIER:  barrier_reg <= cfg_wdata[PW-1:0];
                    bops_pkg::CFG_DISCOUNT: disc_reg    <= cfg_wdata[bops_pkg::DISC_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.take) begin
                if (s_price > high_reg) begin
                    high_reg <= s_price;
                end
                if (s_price < low_reg) begin
                    low_reg <= s_price;
                end
            end
            if (cmd.gate) begin
                high_reg <= '0;
                low_reg  <= '1;
            end
            if (cmd.acc && (count_reg < bops_pkg::CNT_W'(bops_pkg::MAX_PATHS))) begin
                sum_reg   <= sum_reg + bops_pkg::SUM_W'(pay_reg);
                count_reg <= count_reg + 1'b1;
                if (pay_reg > best_reg) begin
                    best_reg <= pay_reg;
                end
                if (pay_reg < worst_reg) begin
                    worst_reg <= pay_reg;
                end
            end
            if (cmd.load_out) begin
                out_valid_reg <= 1'b1;
                if (batch_reg) begin
                    sum_reg   <= '0;
                    best_reg  <= '0;
                    worst_reg <= '1;
                    count_reg <= '0;
                end
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
        if (cmd.take) begin
            last_reg  <= s_price;
            batch_reg <= s_batch_end;
        end
        if (cmd.gate) begin
            value_reg <= value_next;
        end
        if (cmd.mul) begin
            pay_reg <= prod[bops_pkg::FRAC_W +: PW];
        end
        if (cmd.load_out) begin
            out_pay_reg   <= pay_reg;
            out_stats_reg <= batch_reg;
            out_mean_reg  <= batch_reg ? mean : '0;
            out_best_reg  <= batch_reg ? best_reg : '0;
            out_worst_reg <= batch_reg ? worst_reg : '0;
            out_total_reg <= batch_reg ? count_reg : '0;
        end
    end

    assign stat.batch    = batch_reg;
    assign stat.div_done = div_done;
    assign stat.out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_stats_reg;
    assign m_tdata  = {(bops_pkg::M_DATA_W - 4 * PW - bops_pkg::CNT_W)'(0), out_total_reg,
                       out_worst_reg, out_best_reg, out_mean_reg, out_pay_reg};

endmodule

[rtl/core/bops_ctrl.sv]
// Controller state machine that sequences the path end and run end work.
module bops_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tlast,
    output logic                  s_tready,
    input  bops_pkg::ctrl_stat_t  stat,
    output bops_pkg::ctrl_cmd_t   cmd
);

    bops_pkg::state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bops_pkg::ST_IDLE: begin
                if (s_tvalid && s_tlast) begin
                    state_next = bops_pkg::ST_GATE;
                end
            end
            bops_pkg::ST_GATE:   state_next = bops_pkg::ST_MUL;
            bops_pkg::ST_MUL:    state_next = bops_pkg::ST_ACC;
            bops_pkg::ST_ACC:    state_next = stat.batch ? bops_pkg::ST_DSTART : bops_pkg::ST_OUT;
            bops_pkg::ST_DSTART: state_next = bops_pkg::ST_DIV;
            bops_pkg::ST_DIV: begin
                if (stat.div_done) begin
                    state_next = bops_pkg::ST_OUT;
                end
            end
            bops_pkg::ST_OUT: begin
                if (stat.out_free) begin
                    state_next = bops_pkg::ST_IDLE;
                end
            end
            default: state_next = bops_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            bops_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                cmd.take = s_tvalid;
            end
            bops_pkg::ST_GATE:   cmd.gate = 1'b1;
            bops_pkg::ST_MUL:    cmd.mul = 1'b1;
            bops_pkg::ST_ACC:    cmd.acc = 1'b1;
            bops_pkg::ST_DSTART: cmd.div_start = 1'b1;
            bops_pkg::ST_DIV:    ;
            bops_pkg::ST_OUT:    cmd.load_out = stat.out_free;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bops_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[verif/barrier_option_payoff_stats_tb.sv]
// Self-checking testbench for the barrier option payoff statistics block.
module barrier_option_payoff_stats_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bops_pkg::*;

    localparam logic [PRICE_W-1:0] Q_ONE = 32'd4096;  // 1.0 in Q20.12
    localparam int PHASE_ITEMS   = 155;
    localparam int NUM_PHASES    = 12;
    localparam int SETTLE_CYCLES = 80;

    typedef enum logic [KIND_W-1:0] {
        CALL_UP_OUT,
        CALL_UP_IN,
        CALL_DOWN_OUT,
        CALL_DOWN_IN,
        PUT_UP_OUT,
        PUT_UP_IN,
        PUT_DOWN_OUT,
        PUT_DOWN_IN
    } barrier_kind_e;

    class payoff_scoreboard;
        typedef struct {
            bit [PRICE_W-1:0] payoff;
            bit               stats_valid;
            bit [PRICE_W-1:0] mean;
            bit [PRICE_W-1:0] best;
            bit [PRICE_W-1:0] worst;
            bit [CNT_W-1:0]   total;
        } path_result_t;

        bit [KIND_W-1:0]  kind;
        bit [PRICE_W-1:0] strike;
        bit [PRICE_W-1:0] barrier;
        bit [DISC_W-1:0]  disc;
        bit [PRICE_W-1:0] path_hi;
        bit [PRICE_W-1:0] path_lo;
        bit [SUM_W-1:0]   pay_sum;
        bit [PRICE_W-1:0] best_pay;
        bit [PRICE_W-1:0] worst_pay;
        bit [CNT_W-1:0]   counted;
        path_result_t     due_q[$];
        int               errors;

        function new();
            kind    = CALL_UP_OUT;
            strike  = '0;
            barrier = '0;
            disc    = ONE_Q16;
            path_hi = '0;
            path_lo = '1;
            clear_run();
            errors  = 0;
        endfunction

        function void clear_run();
            pay_sum   = '0;
            best_pay  = '0;
            worst_pay = '1;
            counted   = '0;
        endfunction

        function int pending();
            return due_q.size();
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_KIND:     kind    = val[KIND_W-1:0];
                CFG_STRIKE:   strike  = val;
                CFG_BARRIER:  barrier = val;
                CFG_DISCOUNT: disc    = val[DISC_W-1:0];
                default: ;
            endcase
        endfunction

        function bit [PRICE_W-1:0] discounted_payoff(bit [PRICE_W-1:0] last);
            bit               hit;
            bit [PRICE_W-1:0] value;
            bit [DISC_W-1:0]  d;
            bit [PROD_W-1:0]  prod;
            hit = kind[KIND_DOWN] ? (path_lo <= barrier) : (path_hi >= barrier);
            // A discount above one is treated as exactly one.
            d = (disc > ONE_Q16) ? ONE_Q16 : disc;
            value = '0;
            if (hit == kind[KIND_IN]) begin
                if (kind[KIND_PUT])
                    value = (strike > last) ? strike - last : '0;
                else
                    value = (last > strike) ? last - strike : '0;
            end
            prod = value * d;
            return prod[FRAC_W +: PRICE_W];
        endfunction

        function void take_sample(bit [PRICE_W-1:0] price, bit path_end, bit batch_end);
            path_result_t r;
            if (price > path_hi) path_hi = price;
            if (price < path_lo) path_lo = price;
            if (!path_end) return;
            r = '{default: '0};
            r.payoff = discounted_payoff(price);
            path_hi = '0;
            path_lo = '1;
            if (counted < MAX_PATHS) begin
                pay_sum += r.payoff;
                if (r.payoff > best_pay) best_pay = r.payoff;
                if (r.payoff < worst_pay) worst_pay = r.payoff;
                counted++;
            end
            if (batch_end) begin
                r.stats_valid = 1'b1;
                r.mean  = (counted != 0) ? PRICE_W'(pay_sum / counted) : '0;
                r.best  = best_pay;
                r.worst = worst_pay;
                r.total = counted;
                clear_run();
            end
            due_q.push_back(r);
        endfunction

        function void compare_field(string name, logic [PRICE_W-1:0] want,
                                    logic [PRICE_W-1:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [M_DATA_W-1:0] data, logic stats_flag);
            path_result_t r;
            if (due_q.size() == 0) begin
                $error("unexpected result transfer: data=%h stats_valid=%b", data, stats_flag);
                errors++;
                return;
            end
            r = due_q.pop_front();
            compare_field("payoff", r.payoff, data[0 +: PRICE_W]);
            compare_field("stats_valid", r.stats_valid, stats_flag);
            compare_field("mean_payoff", r.mean, data[PRICE_W +: PRICE_W]);
            compare_field("best_payoff", r.best, data[2*PRICE_W +: PRICE_W]);
            compare_field("worst_payoff", r.worst, data[3*PRICE_W +: PRICE_W]);
            compare_field("path_total", r.total, data[4*PRICE_W +: CNT_W]);
        endfunction
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [PRICE_W-1:0]    s_tdata   = '0;   // price
    logic                  s_tlast   = 1'b0; // path_end
    logic                  s_tuser   = 1'b0; // batch_end
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    // payoff, mean_payoff, best_payoff, worst_payoff, path_total, zero fill
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tuser;          // stats_valid

    payoff_scoreboard      sb;
    bit                    calm = 1'b0;
    int                    samples_sent = 0;
    logic [PRICE_W-1:0]    cur_strike  = '0;
    logic [PRICE_W-1:0]    cur_barrier = '0;

    barrier_option_payoff_stats DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #4 aclk = ~aclk;

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= calm || ($urandom_range(0, 99) >= 35);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(m_tdata, m_tuser);
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_sample(logic [PRICE_W-1:0] price, logic path_end, logic batch_end);
        while (!calm && $urandom_range(0, 99) < 35) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= price;
        s_tlast  <= path_end;
        s_tuser  <= batch_end;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.take_sample(price, path_end, batch_end);
        samples_sent++;
        @(negedge aclk);
    endtask

    task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.set_reg(idx, val);
        @(negedge aclk);
    endtask

    // Registers change only once the block has drained every pending result.
    task automatic write_regs(logic [CFG_DATA_W-1:0] kind_word, logic [PRICE_W-1:0] strike,
                              logic [PRICE_W-1:0] barrier, logic [CFG_DATA_W-1:0] disc_word);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        put_reg(CFG_KIND, kind_word);
        put_reg(CFG_STRIKE, strike);
        put_reg(CFG_BARRIER, barrier);
        put_reg(CFG_DISCOUNT, disc_word);
        cfg_wr_en   <= 1'b0;
        cur_strike  = strike;
        cur_barrier = barrier;
    endtask

    // Prices cluster around the barrier and the strike so that both outcomes occur.
    function automatic logic [PRICE_W-1:0] pick_price();
        logic [PRICE_W-1:0] offset;
        offset = $urandom_range(0, 40 * 4096);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return $urandom();
            4, 5, 6: return $urandom_range(0, 1) ? cur_barrier + offset : cur_barrier - offset;
            default: return $urandom_range(0, 1) ? cur_strike + offset : cur_strike - offset;
        endcase
    endfunction

    task automatic send_path(bit closes_run);
        int len;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
            if (i == len - 1)
                send_sample(pick_price(), 1'b1, closes_run);
            else
                send_sample(pick_price(), 1'b0, $urandom_range(0, 11) == 0);
        end
    endtask

    task automatic send_run();
        int paths;
        paths = $urandom_range(1, 8);
        for (int p = 0; p < paths; p++) send_path(p == paths - 1);
    endtask

    initial begin
        int phase_start;
        sb = new();
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // With the reset registers every up-and-out call is knocked out at once.
        send_sample('1, 1'b1, 1'b0);
        send_sample('0, 1'b1, 1'b1);

        write_regs(CALL_UP_OUT, 100 * Q_ONE, 120 * Q_ONE, ONE_Q16);
        send_sample(90 * Q_ONE, 1'b0, 1'b0);
        send_sample(110 * Q_ONE, 1'b1, 1'b0);
        // Touching the barrier earlier in the path knocks it out.
        send_sample(120 * Q_ONE, 1'b0, 1'b0);
        send_sample(105 * Q_ONE, 1'b1, 1'b0);
        // A batch end flag without a path end must be ignored.
        send_sample(95 * Q_ONE, 1'b0, 1'b1);
        send_sample(115 * Q_ONE, 1'b1, 1'b0);
        send_sample(120 * Q_ONE, 1'b1, 1'b0);
        send_sample(120 * Q_ONE - 1, 1'b1, 1'b0);
        send_sample('0, 1'b1, 1'b0);
        send_sample(100 * Q_ONE, 1'b1, 1'b1);
        send_sample(101 * Q_ONE, 1'b1, 1'b1);

        // Discount above one, barrier at zero: only a zero sample knocks in.
        write_regs(PUT_DOWN_IN, '1, '0, 32'h0001_FFFF);
        send_sample(32'd5, 1'b0, 1'b0);
        send_sample('0, 1'b0, 1'b0);
        send_sample(32'd7, 1'b1, 1'b0);
        send_sample('1, 1'b1, 1'b0);
        send_sample(32'd3, 1'b1, 1'b1);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: write_regs(CALL_UP_OUT,   100 * Q_ONE, 120 * Q_ONE, ONE_Q16);
                1: write_regs(CALL_UP_IN,    100 * Q_ONE, 120 * Q_ONE, 32'd60000);
                2: write_regs(CALL_DOWN_OUT, 100 * Q_ONE, 80 * Q_ONE,  ONE_Q16);
                3: write_regs(CALL_DOWN_IN,  100 * Q_ONE, 80 * Q_ONE,  32'd45000);
                4: write_regs(PUT_UP_OUT,    100 * Q_ONE, 120 * Q_ONE, ONE_Q16);
                5: write_regs(PUT_UP_IN,     100 * Q_ONE, 120 * Q_ONE, 32'd65535);
                6: write_regs(PUT_DOWN_OUT,  100 * Q_ONE, 80 * Q_ONE,  32'd32768);
                7: write_regs(PUT_DOWN_IN,   100 * Q_ONE, 80 * Q_ONE,  ONE_Q16);
                8: write_regs(CALL_UP_OUT,   '0, '1, 32'h0001_FFFF);
                9: write_regs(PUT_DOWN_OUT,  '1, '0, '0);
                // Upper write data bits beyond each register's width are junk here.
                default: write_regs($urandom(), $urandom(), $urandom(), $urandom());
            endcase
            calm = (ph == 5);
            phase_start = samples_sent;
            while (samples_sent - phase_start < PHASE_ITEMS) send_run();
        end
        calm = 1'b0;
        s_tvalid <= 1'b0;

        while (sb.pending() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #(10_000_000);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
